// File: src/dllm_pkg.sv
// ----------------------------------------------------------------------------
// dllm_pkg
// shared types and constants of the decaying load latency monitor
// ----------------------------------------------------------------------------
package dllm_pkg;

    localparam int unsigned SumW   = 64;
    localparam int unsigned CntW   = 32;
    localparam int unsigned AddrW  = 3;

    localparam logic [AddrW-1:0] AddrTargetAvg  = 3'd0;
    localparam logic [AddrW-1:0] AddrTargetPeak = 3'd4;

    typedef struct packed {
        logic clear;
        logic decay;
        logic update;
        logic div_start;
        logic load_out;
    } dllm_cmd_t;

    typedef struct packed {
        logic stale;
        logic same;
        logic steps_done;
        logic div_done;
    } dllm_status_t;

endpackage

// File: src/dllm_ctrl.sv
// ----------------------------------------------------------------------------
// dllm_ctrl
// sequencer: time check, decay steps, update, division, output
// ----------------------------------------------------------------------------
module dllm_ctrl
    import dllm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         out_busy,
    input  dllm_status_t status,
    output dllm_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DECAY = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_WAIT  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.stale)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_UPD;
                end
                else if (status.same)
                    state_next = S_UPD;
                else
                    state_next = S_DECAY;
            end
            S_DECAY:
            begin
                cmd.decay = 1'b1;
                if (status.steps_done)
                    state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (status.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// File: src/dllm_div.sv
// ----------------------------------------------------------------------------
// dllm_div
// restoring divider, 64-bit dividend by 34-bit divisor, one bit per cycle
// ----------------------------------------------------------------------------
module dllm_div
    import dllm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [SumW-1:0] dividend,
    input  logic [33:0]     divisor,
    output logic [SumW-1:0] quotient,
    output logic            done
);

    logic [SumW-1:0] quo_reg;
    logic [34:0]     rem_reg;
    logic [33:0]     dvs_reg;
    logic [6:0]      cnt_reg;
    logic            busy_reg;
    logic [34:0]     trial;
    logic [35:0]     diff;

    assign trial    = {rem_reg[33:0], quo_reg[SumW-1]};
    assign diff     = {1'b0, trial} - {2'b00, dvs_reg};
    assign quotient = quo_reg;
    assign done     = !busy_reg && !start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 7'(SumW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[35])
            begin
                rem_reg <= diff[34:0];
                quo_reg <= {quo_reg[SumW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[SumW-2:0], 1'b0};
            end
        end
    end

endmodule

// File: src/dllm_datapath.sv
// ----------------------------------------------------------------------------
// dllm_datapath
// decaying sums, registers, two dividers and output register
// ----------------------------------------------------------------------------
module dllm_datapath
    import dllm_pkg::*;
#(
    parameter int unsigned STALE_SECONDS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  logic [31:0]        now_seconds,
    input  logic               count_job,
    input  logic               has_latency,
    input  logic [19:0]        latency_ms,
    input  logic [31:0]        target_avg,
    input  logic [31:0]        target_peak,
    input  dllm_cmd_t          cmd,
    output dllm_status_t       status,
    input  logic               out_ready,
    output logic               out_valid,
    output logic               out_busy,
    output logic [29:0]        job_rate,
    output logic [31:0]        latency_avg,
    output logic [31:0]        latency_peak,
    output logic               over_target
);

    localparam int unsigned StepW = $clog2(STALE_SECONDS + 1);

    logic [CntW-1:0] job_reg, evt_reg, last_reg, now_reg;
    logic [SumW-1:0] tot_reg, pk_reg;
    logic            cj_reg, hl_reg;
    logic [19:0]     ms_reg;
    logic [StepW-1:0] steps_reg;

    logic [32:0]     diff_t;
    logic [SumW-1:0] tot_add, pk_add;
    logic [CntW-1:0] evt_inc;
    logic [54:0]     floor_pk;
    logic [19:0]     ms_eff;
    logic [SumW-1:0] q_avg, q_pk;
    logic            d0, d1;
    logic            out_valid_reg;

    assign diff_t = {1'b0, now_reg} - {1'b0, last_reg};
    assign status.same  = (now_reg == last_reg);
    assign status.stale = (now_reg < last_reg) ||
                          (diff_t > 33'(STALE_SECONDS));
    assign status.steps_done = (steps_reg == StepW'(1));
    assign status.div_done   = d0 && d1;

    assign ms_eff  = (ms_reg == 20'd1) ? 20'd0 : ms_reg;
    assign evt_inc = (evt_reg == '1) ? evt_reg : evt_reg + 32'd1;
    assign tot_add = (tot_reg > ~{44'd0, ms_eff}) ? '1 : tot_reg + {44'd0, ms_eff};
    assign pk_add  = (pk_reg > ~{44'd0, ms_eff}) ? '1 : pk_reg + {44'd0, ms_eff};
    assign floor_pk = 55'({evt_inc, 2'b00}) * 55'(ms_eff);

    // elapsed seconds, counted down while decaying
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            steps_reg <= '0;
        else if (cmd.decay)
            steps_reg <= steps_reg - StepW'(1);
        else
            steps_reg <= StepW'(diff_t);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_reg   <= '0;
            evt_reg   <= '0;
            tot_reg   <= '0;
            pk_reg    <= '0;
            last_reg  <= '0;
        end
        else if (cmd.clear)
        begin
            job_reg  <= '0;
            evt_reg  <= '0;
            tot_reg  <= '0;
            pk_reg   <= '0;
            last_reg <= now_reg;
        end
        else if (cmd.decay)
        begin
            job_reg <= job_reg - 32'((33'(job_reg) + 33'd3) >> 2);
            evt_reg <= evt_reg - 32'((33'(evt_reg) + 33'd3) >> 2);
            tot_reg <= tot_reg - (tot_reg >> 2);
            pk_reg  <= pk_reg - (pk_reg >> 2);
        end
        else if (cmd.update)
        begin
            last_reg  <= now_reg;
            if (cj_reg && job_reg != '1)
                job_reg <= job_reg + 32'd1;
            if (hl_reg)
            begin
                evt_reg <= evt_inc;
                tot_reg <= tot_add;
                pk_reg  <= (pk_add < {9'd0, floor_pk}) ? {9'd0, floor_pk} : pk_add;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            now_reg <= now_seconds;
            cj_reg  <= count_job;
            hl_reg  <= has_latency;
            ms_reg  <= latency_ms;
        end
    end

    dllm_div u_div_avg (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(tot_reg),
        .divisor({evt_reg, 2'b00}), .quotient(q_avg), .done(d0)
    );

    dllm_div u_div_pk (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(pk_reg),
        .divisor({evt_reg, 2'b00}), .quotient(q_pk), .done(d1)
    );

    logic nz;
    assign nz = (evt_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            job_rate     <= job_reg[31:2];
            latency_avg  <= !nz ? 32'd0 : ((q_avg[63:32] != '0) ? '1 : q_avg[31:0]);
            latency_peak <= !nz ? 32'd0 : ((q_pk[63:32] != '0) ? '1 : q_pk[31:0]);
            over_target  <= nz && (((target_peak != '0) && (q_pk > {32'd0, target_peak})) ||
                                   ((target_avg != '0) && (q_avg > {32'd0, target_avg})));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_busy  = out_valid_reg && !out_ready;

endmodule

// File: src/decaying_load_latency_monitor.sv
// ----------------------------------------------------------------------------
// decaying_load_latency_monitor
// decaying job load and latency sums with average and peak estimates
// ----------------------------------------------------------------------------
// an accepted word passes the time check, one decay step per elapsed second
// (at most STALE_SECONDS), the update and both divisions, plus any wait for the output
// a new word is accepted only once the previous one has left the sequencer, which
// waits for the bit-serial 64-bit dividers
// a result may wait in the output register while the next word is accepted
// asynchronous active-low reset clears all sums, last second and targets
module decaying_load_latency_monitor
    import dllm_pkg::*;
#(
    parameter int unsigned STALE_SECONDS = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [31:0]      now_seconds,
    input  logic             count_job,
    input  logic             has_latency,
    input  logic [19:0]      latency_ms,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [29:0]      job_rate,
    output logic [31:0]      latency_avg,
    output logic [31:0]      latency_peak,
    output logic             over_target
);

    logic [31:0]  target_avg_reg, target_peak_reg;
    dllm_cmd_t    cmd;
    dllm_status_t status;
    logic         out_busy;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_avg_reg  <= '0;
            target_peak_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr)
                AddrTargetAvg:  target_avg_reg  <= pwdata;
                AddrTargetPeak: target_peak_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            AddrTargetAvg:  prdata = target_avg_reg;
            AddrTargetPeak: prdata = target_peak_reg;
            default:        prdata = '0;
        endcase
    end

    dllm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_busy(out_busy), .status(status), .cmd(cmd)
    );

    dllm_datapath #(.STALE_SECONDS(STALE_SECONDS)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_fire(in_valid && in_ready),
        .now_seconds(now_seconds), .count_job(count_job),
        .has_latency(has_latency), .latency_ms(latency_ms),
        .target_avg(target_avg_reg), .target_peak(target_peak_reg),
        .cmd(cmd), .status(status), .out_ready(out_ready),
        .out_valid(out_valid), .out_busy(out_busy), .job_rate(job_rate),
        .latency_avg(latency_avg), .latency_peak(latency_peak),
        .over_target(over_target)
    );

endmodule

// File: src/dllm_checker.sv
// ----------------------------------------------------------------------------
// dllm_checker
// port-level checks of the monitor
// ----------------------------------------------------------------------------
module dllm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] latency_avg,
    input logic        pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(latency_avg))
        else $error("output word dropped while stalled");

    a_no_accept_after: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted second word while busy");

    a_no_out_soon: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 !$rose(out_valid))
        else $error("result too early");

    a_pready: assert property (@(posedge clk) pready)
        else $error("pready low");

endmodule

bind decaying_load_latency_monitor dllm_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .latency_avg(latency_avg),
    .pready(pready)
);
